### src/interval_timer_three_channel_macros.svh
// Assertion macros for the interval timer.
// Empty bodies when SYNTHESIS is defined.
`ifndef INTERVAL_TIMER_THREE_CHANNEL_MACROS_SVH
`define INTERVAL_TIMER_THREE_CHANNEL_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset
`define ITC_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("interval timer check failed");

// Next-cycle implication, disabled while in reset
`define ITC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("interval timer check failed");

`else

`define ITC_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define ITC_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

### src/itc_pkg.sv
package itc_pkg;

    // Number of counters the design is built for
    localparam int MAX_CHANNELS = 3;

    // Word kinds on the input stream
    typedef enum logic [1:0] {
        OP_CTRL = 2'd0,
        OP_DATA = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // Access field of a control word; stored value ACC_LATCH means none set
    typedef enum logic [1:0] {
        ACC_LATCH = 2'd0,
        ACC_LOW   = 2'd1,
        ACC_HIGH  = 2'd2,
        ACC_LOHI  = 2'd3
    } acc_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_READBACK = 2'd2
    } status_t;

    // Counting modes with special handling
    localparam logic [2:0] MODE_RATE   = 3'b010;
    localparam logic [2:0] MODE_SQUARE = 3'b011;
    localparam logic [2:0] MODE_SIX    = 3'b110;
    localparam logic [2:0] MODE_SEVEN  = 3'b111;

    // Channel select value of the read-back command
    localparam logic [1:0] SEL_READBACK = 2'd3;

    localparam logic [15:0] COUNT_FULL = 16'hFFFF;

    // Command to one counter, asserted for one cycle as a word is processed
    typedef struct packed {
        logic       ctrl_wr;
        logic       data_wr;
        logic       tick;
        logic [7:0] data;
    } chan_cmd_t;

    // Counter status back to the top level
    typedef struct packed {
        logic out_level;
        logic loaded;
        logic acc_set;
    } chan_stat_t;

endpackage

### src/itc_channel.sv
module itc_channel
    import itc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  chan_cmd_t  cmd,
    output chan_stat_t stat
);

    logic [15:0] reload_reg, reload_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] latched_reg, latched_next;
    logic        latch_valid_reg, latch_valid_next;
    logic [2:0]  mode_reg, mode_next;
    acc_t        acc_reg, acc_next;
    logic        bcd_reg, bcd_next;
    logic        loaded_reg, loaded_next;
    logic        low_next_reg, low_next_next;
    logic        out_reg, out_next;

    acc_t        cw_acc;
    logic [2:0]  cw_mode;

    // Control word fields, modes six and seven fold onto two and three
    always_comb
    begin
        cw_acc  = acc_t'(cmd.data[5:4]);
        cw_mode = cmd.data[3:1];
        if (cw_mode == MODE_SIX)
        begin
            cw_mode = MODE_RATE;
        end
        else if (cw_mode == MODE_SEVEN)
        begin
            cw_mode = MODE_SQUARE;
        end
    end

    // Next state of the counter
    always_comb
    begin
        reload_next      = reload_reg;
        count_next       = count_reg;
        latched_next     = latched_reg;
        latch_valid_next = latch_valid_reg;
        mode_next        = mode_reg;
        acc_next         = acc_reg;
        bcd_next         = bcd_reg;
        loaded_next      = loaded_reg;
        low_next_next    = low_next_reg;
        out_next         = out_reg;

        // control word: latch count or set up a new load
        if (cmd.ctrl_wr)
        begin
            if (cw_acc == ACC_LATCH)
            begin
                latched_next     = count_reg;
                latch_valid_next = 1'b1;
            end
            else
            begin
                mode_next     = cw_mode;
                acc_next      = cw_acc;
                bcd_next      = cmd.data[0];
                loaded_next   = 1'b0;
                low_next_next = 1'b1;
            end
        end

        // count byte, taken only while waiting for a count
        if (cmd.data_wr && !loaded_reg && (acc_reg != ACC_LATCH))
        begin
            unique case (acc_reg)
                ACC_LOW:
                begin
                    reload_next = {reload_reg[15:8], cmd.data};
                    loaded_next = 1'b1;
                    count_next  = COUNT_FULL;
                end
                ACC_HIGH:
                begin
                    reload_next = {cmd.data, reload_reg[7:0]};
                    loaded_next = 1'b1;
                    count_next  = COUNT_FULL;
                end
                ACC_LOHI:
                begin
                    if (low_next_reg)
                    begin
                        reload_next = {reload_reg[15:8], cmd.data};
                    end
                    else
                    begin
                        reload_next = {cmd.data, reload_reg[7:0]};
                        loaded_next = 1'b1;
                        count_next  = COUNT_FULL;
                    end
                    low_next_next = !low_next_reg;
                end
                default:
                begin
                end
            endcase
        end

        // tick: rate modes reload at zero, others wrap
        if (cmd.tick && loaded_reg)
        begin
            if ((mode_reg == MODE_RATE) || (mode_reg == MODE_SQUARE))
            begin
                if (count_reg != 16'd0)
                begin
                    count_next = count_reg - 16'd1;
                end
                else
                begin
                    count_next = reload_reg;
                end
                out_next = (count_next == reload_reg);
            end
            else
            begin
                count_next = count_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg      <= '0;
            count_reg       <= '0;
            latched_reg     <= '0;
            latch_valid_reg <= 1'b0;
            mode_reg        <= '0;
            acc_reg         <= ACC_LATCH;
            bcd_reg         <= 1'b0;
            loaded_reg      <= 1'b0;
            low_next_reg    <= 1'b1;
            out_reg         <= 1'b0;
        end
        else
        begin
            reload_reg      <= reload_next;
            count_reg       <= count_next;
            latched_reg     <= latched_next;
            latch_valid_reg <= latch_valid_next;
            mode_reg        <= mode_next;
            acc_reg         <= acc_next;
            bcd_reg         <= bcd_next;
            loaded_reg      <= loaded_next;
            low_next_reg    <= low_next_next;
            out_reg         <= out_next;
        end
    end

    // Level after this word, plus the load status seen before it
    assign stat.out_level = out_next;
    assign stat.loaded    = loaded_reg;
    assign stat.acc_set   = (acc_reg != ACC_LATCH);

endmodule

### src/interval_timer_three_channel.sv
// Three-channel 16-bit interval timer. Every input word is a control word, a count
// byte for one channel or a clock tick, and gives exactly one result word with the
// three output levels and a status. One word is accepted every cycle unless results
// back up; each word passes through the input register and then the result register,
// with all counter updates done in the single pass between them. Input keeps flowing
// while a result waits, up to the one word held in the input register.
`include "interval_timer_three_channel_macros.svh"

module interval_timer_three_channel
    import itc_pkg::*;
#(
    parameter int NUM_CHANNELS = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // op[1:0], channel[3:2], data[11:4], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // out0[0], out1[1], out2[2], status[4:3], zero
);

    logic        in_valid_reg, in_valid_next;
    op_t         op_reg, op_next;
    logic [1:0]  chan_reg, chan_next;
    logic [7:0]  data_reg, data_next;

    logic        res_valid_reg, res_valid_next;
    logic [2:0]  res_out_reg, res_out_next;
    status_t     res_status_reg, res_status_next;

    logic        res_free;
    logic        adv;
    logic [1:0]  sel;
    logic [3:0]  data_ok;
    status_t     status;

    chan_cmd_t   cmd  [MAX_CHANNELS];
    chan_stat_t  stat [MAX_CHANNELS];

    // Handshake: result slot free or draining lets the input word through
    assign res_free      = !res_valid_reg || m_axis_tready;
    assign adv           = in_valid_reg && res_free;
    assign s_axis_tready = !in_valid_reg || res_free;
    assign sel           = data_reg[7:6];

    // Per-counter commands and counters
    for (genvar i = 0; i < MAX_CHANNELS; i++)
    begin : g_chan
        assign cmd[i].ctrl_wr = adv && (op_reg == OP_CTRL) && (sel == 2'(i));
        assign cmd[i].data_wr = adv && (op_reg == OP_DATA) && (chan_reg == 2'(i));
        assign cmd[i].tick    = adv && (op_reg == OP_TICK);
        assign cmd[i].data    = data_reg;

        if (i < NUM_CHANNELS)
        begin : g_on
            itc_channel u_chan
            (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd[i]),
                .stat  (stat[i])
            );
        end
        else
        begin : g_off
            assign stat[i] = '0;
        end

        assign data_ok[i] = stat[i].acc_set && !stat[i].loaded;
    end
    assign data_ok[3] = 1'b0;

    // Status of the word in the input register
    always_comb
    begin
        case (op_reg)
            OP_CTRL:
            begin
                if (sel == SEL_READBACK)
                begin
                    status = ST_READBACK;
                end
                else if (int'(sel) >= NUM_CHANNELS)
                begin
                    status = ST_IGNORED;
                end
                else
                begin
                    status = ST_OK;
                end
            end
            OP_DATA:
            begin
                status = data_ok[chan_reg] ? ST_OK : ST_IGNORED;
            end
            OP_TICK:
            begin
                status = ST_OK;
            end
            default:
            begin
                status = ST_IGNORED;
            end
        endcase
    end

    // Input and result registers
    always_comb
    begin
        in_valid_next   = in_valid_reg;
        op_next         = op_reg;
        chan_next       = chan_reg;
        data_next       = data_reg;
        res_valid_next  = res_valid_reg;
        res_out_next    = res_out_reg;
        res_status_next = res_status_reg;

        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
            if (s_axis_tvalid)
            begin
                op_next   = op_t'(s_axis_tdata[1:0]);
                chan_next = s_axis_tdata[3:2];
                data_next = s_axis_tdata[11:4];
            end
        end

        if (res_free)
        begin
            res_valid_next = in_valid_reg;
            if (in_valid_reg)
            begin
                res_out_next    = {stat[2].out_level, stat[1].out_level, stat[0].out_level};
                res_status_next = status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        chan_reg       <= chan_next;
        data_reg       <= data_next;
        res_out_reg    <= res_out_next;
        res_status_reg <= res_status_next;
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {3'b000, res_status_reg, res_out_reg};

    // Checks
    `ITC_ASSERT_IMPLY(a_status_code, clk, rst_n, m_axis_tvalid, m_axis_tdata[4:3] != 2'd3)
    `ITC_ASSERT_IMPLY(a_accept_when_free, clk, rst_n, !res_valid_reg, s_axis_tready)
    `ITC_ASSERT_NEXT(a_word_to_result, clk, rst_n, adv, res_valid_reg)

endmodule

### tb/sv/itc_result_checker.sv
// Watches both streams of the interval timer, predicts one result word per
// accepted input word and compares the two in order.
module itc_result_checker
    import itc_pkg::*;
#(
    parameter int NUM_CHANNELS = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] in_data,    // op[1:0], channel[3:2], data[11:4], zero
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [7:0]  res_data,   // out0[0], out1[1], out2[2], status[4:3], zero
    output int          fail_count,
    output int          pending_results
);

    // Same bit order as the low five bits of a result word
    typedef struct packed {
        status_t status;
        logic    out2;
        logic    out1;
        logic    out0;
    } timer_result_t;

    // Per-counter state
    logic [15:0] reload_val  [MAX_CHANNELS];
    logic [15:0] count_val   [MAX_CHANNELS];
    logic [15:0] latched_val [MAX_CHANNELS];
    logic        latch_flag  [MAX_CHANNELS];
    logic [2:0]  mode_reg    [MAX_CHANNELS];
    acc_t        acc_reg     [MAX_CHANNELS];
    logic        bcd_reg     [MAX_CHANNELS];
    logic        loaded_flag [MAX_CHANNELS];
    logic        low_next    [MAX_CHANNELS];
    logic        level       [MAX_CHANNELS];

    timer_result_t expected_q [$];

    function automatic void clear_timer_state();
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            reload_val[c]  = '0;
            count_val[c]   = '0;
            latched_val[c] = '0;
            latch_flag[c]  = 1'b0;
            mode_reg[c]    = '0;
            acc_reg[c]     = ACC_LATCH;
            bcd_reg[c]     = 1'b0;
            loaded_flag[c] = 1'b0;
            low_next[c]    = 1'b1;
            level[c]       = 1'b0;
        end
    endfunction

    // Applies one input word to the state and returns the result word it gives
    function automatic timer_result_t predict_timer_word(op_t op, logic [1:0] chan,
                                                         logic [7:0] d);
        timer_result_t res;
        logic [1:0]    sel;
        acc_t          acc;
        logic [2:0]    mode;
        sel  = d[7:6];
        acc  = acc_t'(d[5:4]);
        mode = d[3:1];
        res  = '0;
        res.status = ST_OK;
        case (op)
            OP_CTRL:
            begin
                if (sel == SEL_READBACK)
                    res.status = ST_READBACK;
                else if (int'(sel) >= NUM_CHANNELS)
                    res.status = ST_IGNORED;
                else if (acc == ACC_LATCH)
                begin
                    latched_val[sel] = count_val[sel];
                    latch_flag[sel]  = 1'b1;
                end
                else
                begin
                    // modes six and seven alias onto rate and square wave
                    if (mode == MODE_SIX)
                        mode = MODE_RATE;
                    else if (mode == MODE_SEVEN)
                        mode = MODE_SQUARE;
                    mode_reg[sel]    = mode;
                    acc_reg[sel]     = acc;
                    bcd_reg[sel]     = d[0];
                    loaded_flag[sel] = 1'b0;
                    low_next[sel]    = 1'b1;
                end
            end
            OP_DATA:
            begin
                if (int'(chan) >= NUM_CHANNELS || loaded_flag[chan] || acc_reg[chan] == ACC_LATCH)
                    res.status = ST_IGNORED;
                else
                begin
                    case (acc_reg[chan])
                        ACC_LOW:
                        begin
                            reload_val[chan][7:0] = d;
                            loaded_flag[chan]     = 1'b1;
                            count_val[chan]       = COUNT_FULL;
                        end
                        ACC_HIGH:
                        begin
                            reload_val[chan][15:8] = d;
                            loaded_flag[chan]      = 1'b1;
                            count_val[chan]        = COUNT_FULL;
                        end
                        default:
                        begin
                            if (low_next[chan])
                                reload_val[chan][7:0] = d;
                            else
                            begin
                                reload_val[chan][15:8] = d;
                                loaded_flag[chan]      = 1'b1;
                                count_val[chan]        = COUNT_FULL;
                            end
                            low_next[chan] = !low_next[chan];
                        end
                    endcase
                end
            end
            OP_TICK:
            begin
                for (int c = 0; c < NUM_CHANNELS && c < MAX_CHANNELS; c++)
                begin
                    if (loaded_flag[c])
                    begin
                        if (mode_reg[c] == MODE_RATE || mode_reg[c] == MODE_SQUARE)
                        begin
                            // count down, reload at zero; high on the reload value
                            if (count_val[c] != 16'd0)
                                count_val[c] = count_val[c] - 16'd1;
                            else
                                count_val[c] = reload_val[c];
                            level[c] = (count_val[c] == reload_val[c]);
                        end
                        else
                            count_val[c] = count_val[c] - 16'd1;
                    end
                end
            end
            default:
                res.status = ST_IGNORED;
        endcase
        res.out0 = (NUM_CHANNELS > 0) ? level[0] : 1'b0;
        res.out1 = (NUM_CHANNELS > 1) ? level[1] : 1'b0;
        res.out2 = (NUM_CHANNELS > 2) ? level[2] : 1'b0;
        return res;
    endfunction

    function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare result words first, then queue the prediction for a new input word
    always @(posedge clk or negedge rst_n)
    begin : watch
        timer_result_t got;
        timer_result_t want;
        if (!rst_n)
        begin
            clear_timer_state();
            expected_q.delete();
            fail_count      = 0;
            pending_results = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                got = timer_result_t'(res_data[4:0]);
                if (expected_q.size() == 0)
                begin
                    $error("result word %h with nothing expected", res_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("out0", 2'(want.out0), 2'(got.out0));
                    check_field("out1", 2'(want.out1), 2'(got.out1));
                    check_field("out2", 2'(want.out2), 2'(got.out2));
                    check_field("status", want.status, got.status);
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_timer_word(op_t'(in_data[1:0]), in_data[3:2],
                                                        in_data[11:4]));
            pending_results = expected_q.size();
        end
    end

endmodule

### tb/sv/interval_timer_three_channel_test.sv
module interval_timer_three_channel_test;
    import itc_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 520;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // op[1:0], channel[3:2], data[11:4], zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // out0[0], out1[1], out2[2], status[4:3], zero

    int fail_count;
    int pending_results;
    int cycle_count = 0;
    int stall_left  = 0;
    int word_count  = 0;
    bit idling_on   = 1'b1;

    interval_timer_three_channel uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    itc_result_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_data         (s_axis_tdata),
        .res_valid       (m_axis_tvalid),
        .res_ready       (m_axis_tready),
        .res_data        (m_axis_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[interval_timer_three_channel] ERROR");
            $finish;
        end
    end

    // Result side back-pressure in random bursts
    always @(negedge clk)
    begin
        if (!idling_on)
        begin
            stall_left    = 0;
            m_axis_tready = 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready = 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left    = $urandom_range(0, 18);
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = 1'b1;
    end

    function automatic logic [7:0] ctrl_word(logic [1:0] sel, acc_t acc, logic [2:0] mode,
                                             logic bcd);
        return {sel, acc, mode, bcd};
    endfunction

    // Drives one word at the falling edge and holds it until accepted
    task automatic send_word(op_t op, logic [1:0] chan, logic [7:0] d);
        if (idling_on && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'b0000, d, chan, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        if (op != OP_NONE)
            word_count++;
    endtask

    task automatic send_ticks(int n);
        repeat (n)
            send_word(OP_TICK, 2'($urandom), 8'($urandom));
    endtask

    // Control word then the count bytes the access mode asks for
    task automatic program_channel(logic [1:0] chan, acc_t acc, logic [2:0] mode, logic bcd,
                                   logic [15:0] reload);
        send_word(OP_CTRL, 2'($urandom), ctrl_word(chan, acc, mode, bcd));
        if (acc == ACC_LOW || acc == ACC_LOHI)
            send_word(OP_DATA, chan, reload[7:0]);
        if (acc == ACC_HIGH || acc == ACC_LOHI)
            send_word(OP_DATA, chan, reload[15:8]);
    endtask

    initial
    begin : stimulus
        logic [1:0]  chan;
        logic [15:0] reload;
        bit          drained;
        drained = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed: ignored writes, read-back, every op and access mode, mode aliases
        send_word(OP_DATA, 2'd0, 8'hA5);                 // no access mode yet
        send_word(OP_NONE, 2'd3, 8'hFF);
        send_word(OP_CTRL, 2'd0, ctrl_word(SEL_READBACK, ACC_LOHI, MODE_SEVEN, 1'b1));
        send_word(OP_DATA, 2'd3, 8'h5A);                 // no such channel
        send_word(OP_TICK, 2'd0, 8'h00);
        send_word(OP_CTRL, 2'd0, ctrl_word(2'd0, ACC_LOW, 3'd0, 1'b1));
        send_word(OP_DATA, 2'd0, 8'hF0);
        send_word(OP_DATA, 2'd0, 8'h0F);                 // already loaded
        send_word(OP_CTRL, 2'd0, ctrl_word(2'd1, ACC_HIGH, MODE_SIX, 1'b0));
        send_word(OP_DATA, 2'd1, 8'hFF);
        send_word(OP_CTRL, 2'd0, ctrl_word(2'd2, ACC_LOHI, MODE_SEVEN, 1'b0));
        send_word(OP_DATA, 2'd2, 8'hFD);
        // rewrite restarts the byte sequence at the low byte
        send_word(OP_CTRL, 2'd0, ctrl_word(2'd2, ACC_LOHI, MODE_SEVEN, 1'b0));
        send_word(OP_DATA, 2'd2, 8'hFD);
        send_word(OP_DATA, 2'd2, 8'hFF);
        send_ticks(3);
        send_word(OP_CTRL, 2'd0, ctrl_word(2'd0, ACC_LATCH, 3'd5, 1'b1));
        program_channel(2'd1, ACC_LOW, 3'd1, 1'b0, 16'h00FE);
        program_channel(2'd0, ACC_LOHI, 3'd4, 1'b1, 16'hFFFE);
        send_word(OP_CTRL, 2'd0, ctrl_word(2'd2, ACC_HIGH, 3'd5, 1'b0));
        send_ticks(2);

        // random: mostly well-formed loads followed by ticks
        word_count = 0;
        while (word_count < RANDOM_WORDS)
        begin
            if (!drained && word_count >= RANDOM_WORDS / 2)
            begin
                drained       = 1'b1;
                s_axis_tvalid = 1'b0;
                wait (pending_results == 0);
                @(negedge clk);
            end
            chan = 2'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    // reloads mostly near full count so the outputs fire within a few ticks
                    reload = {8'hFF, 8'hFF - 8'($urandom_range(0, 40))};
                    if ($urandom_range(0, 3) == 0)
                        reload = 16'($urandom);
                    program_channel(chan, acc_t'($urandom_range(1, 3)),
                                    3'($urandom_range(0, 7)), 1'($urandom), reload);
                    send_ticks($urandom_range(1, 40));
                end
                6:
                    send_word(OP_CTRL, 2'($urandom),
                              ctrl_word(chan, ACC_LATCH, 3'($urandom), 1'($urandom)));
                7:
                    send_ticks($urandom_range(1, 20));
                8:
                    send_word(op_t'($urandom_range(0, 3)), 2'($urandom), 8'($urandom));
                default:
                begin
                    // broken load: one byte of two, then something else
                    send_word(OP_CTRL, 2'($urandom),
                              ctrl_word(chan, ACC_LOHI, 3'($urandom), 1'($urandom)));
                    send_word(OP_DATA, chan, 8'($urandom));
                    if ($urandom_range(0, 1) == 0)
                        send_ticks(1);
                    else
                        send_word(OP_DATA, 2'd3, 8'($urandom));
                end
            endcase
        end

        // last part without idling: reloads near full count so both rate outputs fire
        idling_on = 1'b0;
        program_channel(2'd0, ACC_LOHI, MODE_RATE, 1'b0,
                        16'hFFFF - 16'($urandom_range(2, 9)));
        program_channel(2'd1, ACC_LOHI, MODE_SQUARE, 1'b0, 16'hFFF0);
        program_channel(2'd2, ACC_LOHI, 3'd0, 1'b0, 16'h1234);
        send_ticks(40);

        s_axis_tvalid = 1'b0;
        wait (pending_results == 0);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("[interval_timer_three_channel] OK");
        else
            $display("[interval_timer_three_channel] ERROR");
        $finish;
    end

endmodule
